FILE: hdl/fnc_pkg.sv
// ----------------------------------------------------------------------------
// fnc_pkg
// shared constants, codes, types and the hot colormap table for the
// frame normalize and colormap core
// ----------------------------------------------------------------------------
package fnc_pkg;

  // frame geometry
  localparam int MAX_SIDE    = 256;
  localparam int POS_W       = $clog2(MAX_SIDE);
  localparam int SIDE_W      = POS_W + 1;
  localparam int ADDR_W      = 2 * POS_W;
  localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int COUNT_W     = ADDR_W + 1;

  // payload widths
  localparam int SAMPLE_W = 32;
  localparam int BYTE_W   = 8;
  localparam int COLOR_W  = 3 * BYTE_W;

  // scaling divider: num = 510*v + peak, den = 2*peak
  localparam int NUM_W  = SAMPLE_W + 9;
  localparam int DEN_W  = SAMPLE_W + 1;
  localparam int QUOT_W = BYTE_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int SIZE_W     = 9;
  localparam int CMAP_W     = 3;
  localparam int FLIP_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLORMAP_SELECT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_SELECT     = 3'd3;

  localparam logic [CMAP_W-1:0] CMAP_GRAY  = 3'd0;
  localparam logic [CMAP_W-1:0] CMAP_RED   = 3'd1;
  localparam logic [CMAP_W-1:0] CMAP_GREEN = 3'd2;
  localparam logic [CMAP_W-1:0] CMAP_BLUE  = 3'd3;
  localparam logic [CMAP_W-1:0] CMAP_HOT   = 3'd4;

  localparam logic [FLIP_W-1:0] FLIP_NONE  = 2'd0;
  localparam logic [FLIP_W-1:0] FLIP_HORIZ = 2'd1;
  localparam logic [FLIP_W-1:0] FLIP_VERT  = 2'd2;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // control sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RD_ADDR,
    ST_RD_MEM,
    ST_DIV_START,
    ST_DIV,
    ST_MAP
  } fnc_state_t;

  // hot colormap, indexed by the scaled byte
  localparam int FullScale  = 255;
  localparam int HotSpan    = 95;
  localparam int GreenStart = 96;
  localparam int BlueStart  = 192;
  localparam int BlueSpan   = 63;

  typedef logic [2**BYTE_W-1:0][COLOR_W-1:0] hot_lut_t;

  function automatic hot_lut_t build_hot_lut();
    hot_lut_t lut;
    int r;
    int g;
    int b;
    for (int q = 0; q < 2**BYTE_W; q++) begin
      r = (q >= HotSpan) ? FullScale : (FullScale * q) / HotSpan;
      if (q <= GreenStart) g = 0;
      else if (q - GreenStart >= HotSpan) g = FullScale;
      else g = (FullScale * (q - GreenStart)) / HotSpan;
      b = (q > BlueStart) ? (FullScale * (q - BlueStart)) / BlueSpan : 0;
      lut[q] = {BYTE_W'(r), BYTE_W'(g), BYTE_W'(b)};
    end
    return lut;
  endfunction

  localparam hot_lut_t HOT_LUT = build_hot_lut();

endpackage

FILE: hdl/fnc_if.sv
// ----------------------------------------------------------------------------
// fnc channel interfaces
// valid/ready channels for command items and color results
// ----------------------------------------------------------------------------
interface fnc_cmd_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [fnc_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink (input valid, input mode, input sample, output ready);
endinterface

interface fnc_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [fnc_pkg::COLOR_W-1:0] color;
  logic                        last_pixel;

  modport source (output valid, output color, output last_pixel, input ready);
  modport sink (input valid, input color, input last_pixel, output ready);
endinterface

FILE: hdl/frame_normalize_colormap_core.sv
// ----------------------------------------------------------------------------
// frame_normalize_colormap_core
// frame store with peak tracking, peak normalization and colormap readout
// ----------------------------------------------------------------------------
// Load transactions (mode 0) write 32-bit counts into a 64K-word frame store,
// row 0 first with x ascending, while the peak count is tracked; once
// width*height counts are in, the frame is ready and each readout transaction
// (mode 1) returns one 24-bit color, rows from height-1 down to 0 with x
// ascending, optionally flipped. Each count is scaled to round-half-up of
// 255*v/peak and mapped through gray, red, green, blue or hot. A load runs
// from acceptance to the next acceptance through the store write and an
// idle state. A readout runs from acceptance to the next acceptance through
// address formation, one frame store read, divider start, the bit-serial
// scaling divider, colormap lookup into the output register and an idle
// state. While the output register still holds a color that has not been
// taken, the colormap step waits, and so does the input.
// A readout before the frame is ready returns nothing. Writing the width or
// height abandons the current frame. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module frame_normalize_colormap_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fnc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fnc_pkg::CFG_DATA_W-1:0] cfg_data,
  fnc_cmd_if.sink                        cmd,
  fnc_pixel_if.source                    pixel
);

  // clamp a configured size to 1..MAX_SIDE
  function automatic logic [fnc_pkg::SIDE_W-1:0] clamp_side(
    input logic [fnc_pkg::SIZE_W-1:0] s
  );
    logic [fnc_pkg::SIDE_W-1:0] res;
    if (s == '0) res = fnc_pkg::SIDE_W'(1);
    else if (s > fnc_pkg::SIZE_W'(fnc_pkg::MAX_SIDE)) res = fnc_pkg::SIDE_W'(fnc_pkg::MAX_SIDE);
    else res = fnc_pkg::SIDE_W'(s);
    return res;
  endfunction

  // configuration registers
  logic [fnc_pkg::SIZE_W-1:0] frame_width;
  logic [fnc_pkg::SIZE_W-1:0] frame_height;
  logic [fnc_pkg::CMAP_W-1:0] colormap_select;
  logic [fnc_pkg::FLIP_W-1:0] flip_select;

  // frame state
  logic [fnc_pkg::SAMPLE_W-1:0] peak_value;
  logic [fnc_pkg::COUNT_W-1:0]  load_index;
  logic                         frame_ready;
  logic [fnc_pkg::POS_W-1:0]    rd_x;     // x of next readout pixel
  logic [fnc_pkg::POS_W-1:0]    rd_rows;  // rows already read in this pass
  logic [fnc_pkg::COUNT_W-1:0]  total;    // width*height, follows the config

  // sequencer
  fnc_pkg::fnc_state_t state;
  fnc_pkg::fnc_state_t state_next;

  // datapath registers
  logic [fnc_pkg::SAMPLE_W-1:0] sample_r;
  logic [fnc_pkg::ADDR_W-1:0]   rd_addr;
  logic                         rd_last;

  // output register
  logic                         pix_valid;
  logic [fnc_pkg::COLOR_W-1:0]  pix_color;
  logic                         pix_last;

  // sequencer outputs
  logic cmd_ready;
  logic ram_we;
  logic div_start;
  logic out_load;

  // combinational datapath
  logic [fnc_pkg::SIDE_W-1:0]   w_c;
  logic [fnc_pkg::SIDE_W-1:0]   h_c;
  logic                         restart;
  logic [fnc_pkg::COUNT_W-1:0]  idx_eff;
  logic [fnc_pkg::COUNT_W-1:0]  idx_inc;
  logic [fnc_pkg::SAMPLE_W-1:0] peak_eff;
  logic [fnc_pkg::SAMPLE_W-1:0] peak_new;
  logic [fnc_pkg::POS_W-1:0]    x_eff;
  logic [fnc_pkg::POS_W-1:0]    y_eff;
  logic [fnc_pkg::ADDR_W-1:0]   addr_calc;
  logic                         x_end;
  logic                         pass_end;
  logic [fnc_pkg::ADDR_W-1:0]   ram_addr;
  logic [fnc_pkg::SAMPLE_W-1:0] ram_rdata;
  logic [fnc_pkg::NUM_W-1:0]    div_num;
  logic [fnc_pkg::DEN_W-1:0]    div_den;
  logic                         div_done;
  logic [fnc_pkg::QUOT_W-1:0]   div_quot;
  logic [fnc_pkg::COLOR_W-1:0]  color_calc;

  assign w_c = clamp_side(frame_width);
  assign h_c = clamp_side(frame_height);

  // load: a full or finished frame is dropped before the new count goes in
  assign restart  = frame_ready || (load_index >= total);
  assign idx_eff  = restart ? '0 : load_index;
  assign idx_inc  = idx_eff + 1'b1;
  assign peak_eff = restart ? '0 : peak_value;
  assign peak_new = (sample_r > peak_eff) ? sample_r : peak_eff;

  // readout position, rows run top-down from height-1, or from row 0 up under vertical flip
  always_comb begin
    x_eff = rd_x;
    y_eff = fnc_pkg::POS_W'(h_c - 1'b1 - fnc_pkg::SIDE_W'(rd_rows));
    if (flip_select == fnc_pkg::FLIP_HORIZ) begin
      x_eff = fnc_pkg::POS_W'(w_c - 1'b1 - fnc_pkg::SIDE_W'(rd_x));
    end else if (flip_select == fnc_pkg::FLIP_VERT) begin
      y_eff = rd_rows;
    end
  end

  assign addr_calc = fnc_pkg::ADDR_W'(y_eff * w_c) + fnc_pkg::ADDR_W'(x_eff);
  assign x_end     = (fnc_pkg::SIDE_W'(rd_x) == w_c - 1'b1);
  assign pass_end  = x_end && (fnc_pkg::SIDE_W'(rd_rows) == h_c - 1'b1);

  // store address: load index while loading, else the registered read address
  assign ram_addr = (state == fnc_pkg::ST_LOAD) ? idx_eff[fnc_pkg::ADDR_W-1:0] : rd_addr;

  fnc_ram #(
    .WIDTH (fnc_pkg::SAMPLE_W),
    .DEPTH (fnc_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (sample_r),
    .rdata (ram_rdata)
  );

  // round-half-up of 255*v/peak as floor((510*v + peak) / (2*peak))
  assign div_num = (fnc_pkg::NUM_W'(ram_rdata) << 9) - (fnc_pkg::NUM_W'(ram_rdata) << 1)
                 + fnc_pkg::NUM_W'(peak_value);
  assign div_den = {peak_value, 1'b0};

  fnc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // colormap; a zero peak gives black whatever the map
  always_comb begin
    unique case (colormap_select)
      fnc_pkg::CMAP_RED:   color_calc = {div_quot, 16'h0000};
      fnc_pkg::CMAP_GREEN: color_calc = {8'h00, div_quot, 8'h00};
      fnc_pkg::CMAP_BLUE:  color_calc = {16'h0000, div_quot};
      fnc_pkg::CMAP_HOT:   color_calc = fnc_pkg::HOT_LUT[div_quot];
      default:             color_calc = {div_quot, div_quot, div_quot};
    endcase
    if (peak_value == '0) begin
      color_calc = '0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fnc_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          state_next = (cmd.mode == fnc_pkg::MODE_LOAD) ? fnc_pkg::ST_LOAD
                                                        : fnc_pkg::ST_RD_ADDR;
        end
      end
      fnc_pkg::ST_LOAD:      state_next = fnc_pkg::ST_IDLE;
      fnc_pkg::ST_RD_ADDR: begin
        // readout of a frame not yet ready ends here with no result
        state_next = frame_ready ? fnc_pkg::ST_RD_MEM : fnc_pkg::ST_IDLE;
      end
      fnc_pkg::ST_RD_MEM:    state_next = fnc_pkg::ST_DIV_START;
      fnc_pkg::ST_DIV_START: state_next = fnc_pkg::ST_DIV;
      fnc_pkg::ST_DIV: begin
        if (div_done) state_next = fnc_pkg::ST_MAP;
      end
      fnc_pkg::ST_MAP: begin
        if (!pix_valid || pixel.ready) state_next = fnc_pkg::ST_IDLE;
      end
      default:               state_next = fnc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd_ready = (state == fnc_pkg::ST_IDLE);
    ram_we    = (state == fnc_pkg::ST_LOAD);
    div_start = (state == fnc_pkg::ST_DIV_START);
    out_load  = (state == fnc_pkg::ST_MAP) && (!pix_valid || pixel.ready);
  end

  assign cmd.ready        = cmd_ready;
  assign pixel.valid      = pix_valid;
  assign pixel.color      = pix_color;
  assign pixel.last_pixel = pix_last;

  // control state, frame state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= fnc_pkg::ST_IDLE;
      frame_width     <= fnc_pkg::SIZE_W'(fnc_pkg::MAX_SIDE);
      frame_height    <= fnc_pkg::SIZE_W'(fnc_pkg::MAX_SIDE);
      colormap_select <= fnc_pkg::CMAP_GRAY;
      flip_select     <= fnc_pkg::FLIP_NONE;
      peak_value      <= '0;
      load_index      <= '0;
      frame_ready     <= 1'b0;
      rd_x            <= '0;
      rd_rows         <= '0;
      total           <= '0;
      pix_valid       <= 1'b0;
    end else begin
      state <= state_next;
      total <= fnc_pkg::COUNT_W'(w_c * h_c);

      // load transaction; a new frame or a completed one restarts the pass
      if (state == fnc_pkg::ST_LOAD) begin
        peak_value <= peak_new;
        load_index <= idx_inc;
        if (restart || (idx_inc >= total)) begin
          rd_x    <= '0;
          rd_rows <= '0;
        end
        if (idx_inc >= total) begin
          frame_ready <= 1'b1;
        end else begin
          frame_ready <= 1'b0;
        end
      end

      // step the readout position, wrap at end of pass
      if (state == fnc_pkg::ST_RD_ADDR && frame_ready) begin
        if (pass_end) begin
          rd_x    <= '0;
          rd_rows <= '0;
        end else if (x_end) begin
          rd_x    <= '0;
          rd_rows <= rd_rows + 1'b1;
        end else begin
          rd_x <= rd_x + 1'b1;
        end
      end

      // output register
      if (out_load) begin
        pix_valid <= 1'b1;
      end else if (pixel.ready) begin
        pix_valid <= 1'b0;
      end

      // configuration, to be written only while idle; the block itself does not enforce this
      if (cfg_we) begin
        unique case (cfg_index)
          fnc_pkg::CFG_FRAME_WIDTH: begin
            frame_width <= cfg_data;
            peak_value  <= '0;
            load_index  <= '0;
            frame_ready <= 1'b0;
            rd_x        <= '0;
            rd_rows     <= '0;
          end
          fnc_pkg::CFG_FRAME_HEIGHT: begin
            frame_height <= cfg_data;
            peak_value   <= '0;
            load_index   <= '0;
            frame_ready  <= 1'b0;
            rd_x         <= '0;
            rd_rows      <= '0;
          end
          fnc_pkg::CFG_COLORMAP_SELECT: colormap_select <= cfg_data[fnc_pkg::CMAP_W-1:0];
          fnc_pkg::CFG_FLIP_SELECT:     flip_select     <= cfg_data[fnc_pkg::FLIP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd_ready) begin
      sample_r <= cmd.sample;
    end
    if (state == fnc_pkg::ST_RD_ADDR) begin
      rd_addr <= addr_calc;
      rd_last <= pass_end;
    end
    if (out_load) begin
      pix_color <= color_calc;
      pix_last  <= rd_last;
    end
  end

endmodule

FILE: hdl/fnc_ram.sv
// ----------------------------------------------------------------------------
// fnc_ram
// single-port synchronous ram with registered read data
// ----------------------------------------------------------------------------
module fnc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hdl/fnc_div.sv
// ----------------------------------------------------------------------------
// fnc_div
// restoring divider, one quotient bit per cycle, byte-wide quotient
// ----------------------------------------------------------------------------
module fnc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [fnc_pkg::NUM_W-1:0]  num,
  input  logic [fnc_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [fnc_pkg::QUOT_W-1:0] quot
);

  localparam int CNT_W = $clog2(fnc_pkg::QUOT_W);

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [fnc_pkg::NUM_W-1:0]  rem;
  logic [fnc_pkg::NUM_W-1:0]  dsh;
  logic                       fits;

  // quotient stays below 2^QUOT_W since each count is at most the peak
  assign fits = (rem >= dsh);
  assign done = busy && (cnt == CNT_W'(fnc_pkg::QUOT_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= fnc_pkg::NUM_W'(den) << (fnc_pkg::QUOT_W - 1);
      quot <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quot <= {quot[fnc_pkg::QUOT_W-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_normalize_colormap_core testbench
// loads small and full-side frames of counts, reads them back through every
// colormap and flip setting, and checks each color and pass-end flag against
// a cycle-free prediction of the normalize and colormap pipeline
// ----------------------------------------------------------------------------

// hot colormap breakpoints
localparam int unsigned HOT_FULL        = 255;
localparam int unsigned HOT_SPAN        = 95;
localparam int unsigned HOT_GREEN_START = 96;
localparam int unsigned HOT_BLUE_START  = 192;
localparam int unsigned HOT_BLUE_SPAN   = 63;
localparam int unsigned REPORT_LIMIT    = 10;

class pixel_scoreboard;
  typedef struct packed {
    logic [fnc_pkg::COLOR_W-1:0] color;
    logic                        last_pixel;
  } pixel_t;

  logic [fnc_pkg::SAMPLE_W-1:0] counts [fnc_pkg::STORE_DEPTH];
  logic [fnc_pkg::SAMPLE_W-1:0] peak;
  int unsigned                  load_pos;
  int unsigned                  read_pos;
  bit                           frame_done;
  logic [fnc_pkg::SIZE_W-1:0]   width_raw;
  logic [fnc_pkg::SIZE_W-1:0]   height_raw;
  logic [fnc_pkg::CMAP_W-1:0]   cmap;
  logic [fnc_pkg::FLIP_W-1:0]   flip;
  pixel_t                       expected_pixels [$];
  int unsigned                  mismatches;

  function new();
    width_raw  = fnc_pkg::SIZE_W'(fnc_pkg::MAX_SIDE);
    height_raw = fnc_pkg::SIZE_W'(fnc_pkg::MAX_SIDE);
    cmap       = fnc_pkg::CMAP_GRAY;
    flip       = fnc_pkg::FLIP_NONE;
    mismatches = 0;
    restart_frame();
  endfunction

  function void restart_frame();
    peak       = '0;
    load_pos   = 0;
    read_pos   = 0;
    frame_done = 1'b0;
  endfunction

  // size in use for a raw register value
  function int unsigned side(logic [fnc_pkg::SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > fnc_pkg::MAX_SIDE) return fnc_pkg::MAX_SIDE;
    return 32'(s);
  endfunction

  // round-half-up of 255*v/peak
  function logic [fnc_pkg::BYTE_W-1:0] scale(logic [fnc_pkg::SAMPLE_W-1:0] v);
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    if (peak == 0) return '0;
    num = 64'd510 * v + peak;
    den = {peak, 1'b0};
    q   = num / den;
    return (q > 255) ? fnc_pkg::BYTE_W'(255) : fnc_pkg::BYTE_W'(q);
  endfunction

  function logic [fnc_pkg::COLOR_W-1:0] hot_color(logic [fnc_pkg::BYTE_W-1:0] q);
    int unsigned qi;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    qi = 32'(q);
    r  = (qi >= HOT_SPAN) ? HOT_FULL : (HOT_FULL * qi) / HOT_SPAN;
    if (qi <= HOT_GREEN_START) g = 0;
    else if (qi - HOT_GREEN_START >= HOT_SPAN) g = HOT_FULL;
    else g = (HOT_FULL * (qi - HOT_GREEN_START)) / HOT_SPAN;
    b = (qi > HOT_BLUE_START) ? (HOT_FULL * (qi - HOT_BLUE_START)) / HOT_BLUE_SPAN : 0;
    return {fnc_pkg::BYTE_W'(r), fnc_pkg::BYTE_W'(g), fnc_pkg::BYTE_W'(b)};
  endfunction

  function logic [fnc_pkg::COLOR_W-1:0] colorize(logic [fnc_pkg::BYTE_W-1:0] q);
    case (cmap)
      fnc_pkg::CMAP_RED:   return {q, 16'h0};
      fnc_pkg::CMAP_GREEN: return {8'h0, q, 8'h0};
      fnc_pkg::CMAP_BLUE:  return {16'h0, q};
      fnc_pkg::CMAP_HOT:   return hot_color(q);
      default:             return {q, q, q};
    endcase
  endfunction

  function void write_reg(logic [fnc_pkg::CFG_IDX_W-1:0] idx,
                          logic [fnc_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      fnc_pkg::CFG_FRAME_WIDTH: begin
        width_raw = data[fnc_pkg::SIZE_W-1:0];
        restart_frame();
      end
      fnc_pkg::CFG_FRAME_HEIGHT: begin
        height_raw = data[fnc_pkg::SIZE_W-1:0];
        restart_frame();
      end
      fnc_pkg::CFG_COLORMAP_SELECT: cmap = data[fnc_pkg::CMAP_W-1:0];
      fnc_pkg::CFG_FLIP_SELECT:     flip = data[fnc_pkg::FLIP_W-1:0];
      default: ;
    endcase
  endfunction

  function void note_command(logic mode, logic [fnc_pkg::SAMPLE_W-1:0] sample);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned row;
    int unsigned x;
    int unsigned y;
    pixel_t      px;
    w     = side(width_raw);
    h     = side(height_raw);
    total = w * h;
    if (mode == fnc_pkg::MODE_LOAD) begin
      if (frame_done || load_pos >= total) restart_frame();
      counts[load_pos % fnc_pkg::STORE_DEPTH] = sample;
      if (sample > peak) peak = sample;
      load_pos++;
      if (load_pos >= total) begin
        frame_done = 1'b1;
        read_pos   = 0;
      end
      return;
    end
    if (!frame_done) return;
    if (read_pos >= total) read_pos = 0;
    row = (h - 1) - read_pos / w;
    x   = read_pos % w;
    y   = row;
    if (flip == fnc_pkg::FLIP_HORIZ) x = w - 1 - x;
    else if (flip == fnc_pkg::FLIP_VERT) y = h - 1 - row;
    px.color      = (peak == 0) ? '0
                                : colorize(scale(counts[(y * w + x) % fnc_pkg::STORE_DEPTH]));
    px.last_pixel = (read_pos == total - 1);
    read_pos      = px.last_pixel ? 0 : read_pos + 1;
    expected_pixels.push_back(px);
  endfunction

  function void check_pixel(logic [fnc_pkg::COLOR_W-1:0] color, logic last_pixel);
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      if (mismatches < REPORT_LIMIT)
        $display("unexpected pixel: color %06h last_pixel %b", color, last_pixel);
      mismatches++;
      return;
    end
    want = expected_pixels.pop_front();
    if (color !== want.color || last_pixel !== want.last_pixel) begin
      if (mismatches < REPORT_LIMIT)
        $display("pixel mismatch: expected color %06h last_pixel %b, got color %06h last_pixel %b",
                 want.color, want.last_pixel, color, last_pixel);
      mismatches++;
    end
  endfunction

  function int unsigned pending();
    return expected_pixels.size();
  endfunction
endclass

module testbench;
  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 9;
  localparam int TIMEOUT_CYCLES = 500000;
  localparam int SETTLE_CYCLES  = 24;   // outlasts a whole readout transaction
  localparam int LONG_HOLD      = 300;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int HOLD_AFTER     = 600;
  localparam int PAUSE_AFTER    = 1000;

  // counts that land on the hot map breakpoints when the peak is 255
  localparam logic [fnc_pkg::SAMPLE_W-1:0] HOT_PROBE [8] =
    '{255, 94, 95, 96, 97, 191, 192, 193};

  typedef enum int {FILL_RANDOM, FILL_RAMP, FILL_ZERO, FILL_EXTREME, FILL_SMALL} fill_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [fnc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fnc_pkg::CFG_DATA_W-1:0] cfg_data;

  fnc_cmd_if   cmd ();
  fnc_pixel_if pixel ();

  frame_normalize_colormap_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .pixel     (pixel)
  );

  pixel_scoreboard            sb;
  int unsigned                cycle_count;
  int unsigned                items;          // random-part transactions that count
  bit                         quiet;          // no idling on either side
  bit                         long_hold_req;  // ask the sink for one long stall
  bit                         pause_done;
  logic [fnc_pkg::SIZE_W-1:0] frame_w_raw;
  logic [fnc_pkg::SIZE_W-1:0] frame_h_raw;

  // free-running clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // run limit, counted in cycles
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < TIMEOUT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("frame_normalize_colormap_core test failed");
    $finish;
  end

  // monitors: every accepted transaction is sampled at the rising edge
  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (cmd.valid === 1'b1 && cmd.ready === 1'b1)
        sb.note_command(cmd.mode, cmd.sample);
      if (pixel.valid === 1'b1 && pixel.ready === 1'b1)
        sb.check_pixel(pixel.color, pixel.last_pixel);
    end
  end

  // result sink: random stall bursts, one long hold on request
  initial begin : result_sink
    int unsigned held;
    pixel.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        // long hold counted here, while the sender keeps offering
        long_hold_req = 1'b0;
        pixel.ready <= 1'b0;
        held = 0;
        while (held < LONG_HOLD) begin
          @(negedge clk);
          held++;
        end
        pixel.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        pixel.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        pixel.ready <= 1'b1;
      end else begin
        pixel.ready <= 1'b1;
      end
    end
  end

  // one command transaction; valid stays high into the next item
  // unless a random gap follows
  task automatic send_item(input logic mode, input logic [fnc_pkg::SAMPLE_W-1:0] sample);
    cmd.valid  <= 1'b1;
    cmd.mode   <= mode;
    cmd.sample <= sample;
    do @(posedge clk); while (cmd.ready !== 1'b1);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  // stop offering until every predicted pixel has come out
  task automatic drain_results();
    cmd.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic cfg_write(input logic [fnc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fnc_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // reprogram while idle: sizes only on resize (that drops the frame)
  task automatic setup_frame(input bit resize, input logic [fnc_pkg::SIZE_W-1:0] w,
                             input logic [fnc_pkg::SIZE_W-1:0] h,
                             input logic [fnc_pkg::CMAP_W-1:0] cmap,
                             input logic [fnc_pkg::FLIP_W-1:0] flip);
    logic [fnc_pkg::CFG_DATA_W-1:0] data;
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (resize) begin
      cfg_write(fnc_pkg::CFG_FRAME_WIDTH, w);
      cfg_write(fnc_pkg::CFG_FRAME_HEIGHT, h);
      frame_w_raw = w;
      frame_h_raw = h;
    end
    // upper data bits are don't-care for the narrow registers
    data = ($urandom_range(0, 1) == 0) ? '0 : fnc_pkg::CFG_DATA_W'($urandom);
    data[fnc_pkg::CMAP_W-1:0] = cmap;
    cfg_write(fnc_pkg::CFG_COLORMAP_SELECT, data);
    data = ($urandom_range(0, 1) == 0) ? '0 : fnc_pkg::CFG_DATA_W'($urandom);
    data[fnc_pkg::FLIP_W-1:0] = flip;
    cfg_write(fnc_pkg::CFG_FLIP_SELECT, data);
    // writes to unmapped indexes must change nothing
    if ($urandom_range(0, 3) == 0)
      cfg_write(fnc_pkg::CFG_IDX_W'($urandom_range(fnc_pkg::CFG_FLIP_SELECT + 1,
                                                   2**fnc_pkg::CFG_IDX_W - 1)),
                fnc_pkg::CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // load frame positions start..stop-1 with counts of the given shape
  task automatic load_span(input int unsigned start, input int unsigned stop, input fill_t fill,
                           input int unsigned peak_pos);
    logic [fnc_pkg::SAMPLE_W-1:0] sample;
    for (int unsigned pos = start; pos < stop; pos++) begin
      case (fill)
        FILL_RAMP: sample = (pos == peak_pos) ? 255 : $urandom_range(0, 255);
        FILL_ZERO: sample = '0;
        FILL_SMALL: sample = $urandom_range(0, 15);
        FILL_EXTREME: begin
          if (pos == peak_pos) sample = '1;
          else begin
            case ($urandom_range(0, 4))
              0: sample = '0;
              1: sample = '1;
              2: sample = 32'h7FFF_FFFF;
              3: sample = 32'h8000_0000;
              default: sample = $urandom;
            endcase
          end
        end
        default: sample = $urandom;
      endcase
      send_item(fnc_pkg::MODE_LOAD, sample);
      items++;
    end
  endtask

  // readout transactions; once in mid-run, and now and then at random, the sender waits for the pipe to empty
  task automatic read_pixels(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ((i == n / 2 && items >= PAUSE_AFTER && !pause_done) || $urandom_range(0, 199) == 0) begin
        drain_results();
        if (items >= PAUSE_AFTER) pause_done = 1'b1;
      end
      send_item(fnc_pkg::MODE_READ, $urandom);
      items++;
    end
  endtask

  initial begin : stimulus
    int unsigned                total;
    int unsigned                n;
    int unsigned                k;
    bit                         resize;
    bit                         keep;
    bit                         hold_done;
    fill_t                      fill;
    logic [fnc_pkg::SIZE_W-1:0] w;
    logic [fnc_pkg::SIZE_W-1:0] h;

    sb            = new();
    items         = 0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    pause_done    = 1'b0;
    hold_done     = 1'b0;
    frame_w_raw   = fnc_pkg::SIZE_W'(fnc_pkg::MAX_SIDE);
    frame_h_raw   = fnc_pkg::SIZE_W'(fnc_pkg::MAX_SIDE);

    // every input known from time zero
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    cmd.valid  = 1'b0;
    cmd.mode   = fnc_pkg::MODE_LOAD;
    cmd.sample = '0;

    // single synchronous reset at the start
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed part ----
    // readout before any frame is loaded: no pixel comes back
    send_item(fnc_pkg::MODE_READ, $urandom);

    // hot map breakpoints with peak 255, 4x2 frame
    setup_frame(1'b1, fnc_pkg::SIZE_W'(4), fnc_pkg::SIZE_W'(2), fnc_pkg::CMAP_HOT,
                fnc_pkg::FLIP_NONE);
    for (int i = 0; i < 8; i++) send_item(fnc_pkg::MODE_LOAD, HOT_PROBE[i]);
    read_pixels(8);

    // full-scale counts, rounding near one half, horizontal flip, pass wrap
    setup_frame(1'b1, fnc_pkg::SIZE_W'(2), fnc_pkg::SIZE_W'(1), fnc_pkg::CMAP_GRAY,
                fnc_pkg::FLIP_HORIZ);
    send_item(fnc_pkg::MODE_LOAD, 32'hFFFF_FFFF);
    send_item(fnc_pkg::MODE_LOAD, 32'h7FFF_FFFF);
    read_pixels(3);

    // zero peak gives black, vertical flip
    setup_frame(1'b1, fnc_pkg::SIZE_W'(1), fnc_pkg::SIZE_W'(2), fnc_pkg::CMAP_RED,
                fnc_pkg::FLIP_VERT);
    send_item(fnc_pkg::MODE_LOAD, '0);
    send_item(fnc_pkg::MODE_LOAD, '0);
    read_pixels(2);

    // ---- random part ----
    items = 0;
    while (items < RANDOM_ITEMS) begin
      // last stretch runs with no idling at all
      if (items >= RANDOM_ITEMS * 4 / 5) quiet = 1'b1;

      keep   = ($urandom_range(0, 4) == 0);
      resize = !keep && ($urandom_range(0, 2) != 0);
      w = frame_w_raw;
      h = frame_h_raw;
      if (resize) begin
        case ($urandom_range(0, 19))
          0: begin
            w = fnc_pkg::SIZE_W'($urandom_range(128, 511));
            h = fnc_pkg::SIZE_W'($urandom_range(0, 1));
          end
          1: begin
            w = fnc_pkg::SIZE_W'($urandom_range(0, 1));
            h = fnc_pkg::SIZE_W'($urandom_range(128, 511));
          end
          2: begin
            w = '0;
            h = fnc_pkg::SIZE_W'($urandom_range(0, 9));
          end
          3: begin
            w = fnc_pkg::SIZE_W'($urandom_range(1, 9));
            h = '0;
          end
          default: begin
            w = fnc_pkg::SIZE_W'($urandom_range(1, 9));
            h = fnc_pkg::SIZE_W'($urandom_range(1, 9));
          end
        endcase
      end
      setup_frame(resize, w, h, fnc_pkg::CMAP_W'($urandom_range(0, 7)),
                  fnc_pkg::FLIP_W'($urandom_range(0, 3)));
      total = sb.side(frame_w_raw) * sb.side(frame_h_raw);

      if (!keep) begin
        // noise: readouts on a dropped frame produce nothing
        if (resize && $urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, 3)) send_item(fnc_pkg::MODE_READ, $urandom);
        fill = fill_t'($urandom_range(0, 4));
        k    = $urandom_range(0, total - 1);   // peak position
        if (total > 1 && $urandom_range(0, 6) == 0) begin
          // broken load: readouts in the middle of a partial frame
          n = $urandom_range(1, total - 1);
          load_span(0, n, fill, k);
          repeat ($urandom_range(1, 3)) send_item(fnc_pkg::MODE_READ, $urandom);
          load_span(n, total, fill, k);
        end else begin
          load_span(0, total, fill, k);
        end
      end

      if (total > 64)
        n = ($urandom_range(0, 1) == 0) ? total + $urandom_range(0, 4) : $urandom_range(1, 16);
      else
        n = total * $urandom_range(1, 2) + $urandom_range(0, total);

      // one long receiver stall while readouts keep coming
      if (items >= HOLD_AFTER && !hold_done) begin
        hold_done     = 1'b1;
        long_hold_req = 1'b1;
        if (n < 32) n = 32;
      end
      read_pixels(n);
    end

    // ---- end of run ----
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("frame_normalize_colormap_core test passed");
    end else begin
      $display("frame_normalize_colormap_core test failed");
    end
    $finish;
  end

endmodule
